// ===== design/moving_box_scan_point_marker_assert.svh =====
// Assertion macros for the moving box scan point marker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef MOVING_BOX_SCAN_POINT_MARKER_ASSERT_SVH
`define MOVING_BOX_SCAN_POINT_MARKER_ASSERT_SVH
// same-cycle implication
`define MBSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MBSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== design/mbsp_pkg.sv =====
// Shared types, codes and constant tables of the moving box scan point marker.
// No dependencies.
package mbsp_pkg;
	localparam int CORNERS         = 4;
	localparam int MAX_BOXES_DEF   = 32;
	localparam int TRIG_FRAC_DEF   = 15;
	localparam int TERMS           = 7;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [15:0] MIN_SPEED_RST = 16'd300;
	localparam logic [15:0] MARK_MASK_RST = 16'd1;

	localparam logic [1:0] REQ_CLEAR    = 2'd0;
	localparam logic [1:0] REQ_ADD      = 2'd1;
	localparam logic [1:0] REQ_CLASSIFY = 2'd2;

	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] CFG_MIN_SPEED = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_MARK_MASK = 2'd1;

	typedef struct packed {
		logic                      valid;
		logic [CORNERS-1:0][31:0]  cx;
		logic [CORNERS-1:0][31:0]  cy;
	} box_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} chain_ctl_t;

	typedef struct packed {
		logic signed [31:0] obj_x;
		logic signed [31:0] obj_y;
		logic [15:0]        heading;
		logic [15:0]        size_x;
		logic [15:0]        size_y;
		logic signed [15:0] speed_x;
		logic signed [15:0] speed_y;
	} ld_req_t;

	typedef struct packed {
		logic done;
		box_t box;
	} ld_res_t;

	function automatic logic [7:0] sin_div(input logic [2:0] n);
		case (n)
			3'd1: return 8'd6;
			3'd2: return 8'd20;
			3'd3: return 8'd42;
			3'd4: return 8'd72;
			3'd5: return 8'd110;
			3'd6: return 8'd156;
			3'd7: return 8'd210;
			default: return 8'd1;
		endcase
	endfunction

	function automatic logic [7:0] cos_div(input logic [2:0] n);
		case (n)
			3'd1: return 8'd2;
			3'd2: return 8'd12;
			3'd3: return 8'd30;
			3'd4: return 8'd56;
			3'd5: return 8'd90;
			3'd6: return 8'd132;
			3'd7: return 8'd182;
			default: return 8'd1;
		endcase
	endfunction

	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic [32:0] n;
		n = v[32] ? 33'(-v) : 33'(v);
		return n[31:0];
	endfunction
endpackage

// ===== design/mbsp_cell.sv =====
// One cell of the box chain: holds one box and passes it to the next cell.
// Depends on mbsp_pkg.
module mbsp_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mbsp_pkg::chain_ctl_t ctl,
	input  mbsp_pkg::box_t     din,
	output mbsp_pkg::box_t     dout
);
	import mbsp_pkg::*;

	logic                     valid_q;
	logic [CORNERS-1:0][31:0] cx_q;
	logic [CORNERS-1:0][31:0] cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			cx_q <= din.cx;
			cy_q <= din.cy;
		end
	end

	assign dout = '{valid: valid_q, cx: cx_q, cy: cy_q};
endmodule

// ===== design/mbsp_cdiv.sv =====
// Divider by a small constant, four quotient bits per cycle.
// Depends on mbsp_pkg.
module mbsp_cdiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [31:0] quot
);
	import mbsp_pkg::*;

	localparam int STEPS = 9;

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [7:0]  rem_q;
	logic [7:0]  dv_q;
	logic [35:0] sh_q;
	logic [7:0]  rem_n;
	logic [35:0] sh_n;

	always_comb begin
		logic [8:0] r9;
		rem_n = rem_q;
		sh_n  = sh_q;
		for (int i = 0; i < 4; i++) begin
			r9   = {rem_n, sh_n[35]};
			sh_n = {sh_n[34:0], 1'b0};
			if (r9 >= {1'b0, dv_q}) begin
				rem_n   = 8'(r9 - {1'b0, dv_q});
				sh_n[0] = 1'b1;
			end else begin
				rem_n = r9[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dv_q   <= '0;
			sh_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dv_q   <= divisor;
				sh_q   <= {2'b00, dividend};
			end else if (busy_q) begin
				rem_q <= rem_n;
				sh_q  <= sh_n;
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = sh_q[31:0];
endmodule

// ===== design/mbsp_objld.sv =====
// Object loader: speed check, series sine and cosine, box corner rotation.
// Depends on mbsp_pkg and mbsp_cdiv.
module mbsp_objld #(
	parameter int TRIG_FRAC_BITS = mbsp_pkg::TRIG_FRAC_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mbsp_pkg::ld_req_t req,
	input  logic              full,
	input  logic [15:0]       min_speed,
	output logic              busy,
	output mbsp_pkg::ld_res_t res
);
	import mbsp_pkg::*;

	localparam int F     = TRIG_FRAC_BITS;
	localparam int SHIFT = 30 - F;
	localparam int PW    = F + 18;
	localparam int SW    = (F + 19 > 33) ? F + 19 : 33;
	localparam logic [34:0] HALF = 35'((64'd1 << SHIFT) >> 1);
	localparam logic [34:0] CAP  = 35'((64'd1 << F) - 64'd1);
	localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;

	typedef enum logic [4:0] {
		L_IDLE, L_SQ, L_CHK, L_XW, L_XC, L_X2W, L_X2C, L_TW, L_TC, L_TD,
		L_UW, L_UC, L_UD, L_FRAC, L_PS, L_PW, L_PC, L_CS, L_CO, L_DONE
	} ld_state_t;

	ld_state_t state_q;
	ld_req_t   req_q;
	logic      full_q;
	logic [15:0] ms_q;
	logic [31:0] sqx_q, sqy_q, msq_q;
	logic [31:0] mul_a_q, mul_b_q;
	logic [63:0] prod_q;
	logic [31:0] x2_q, t_q, u_q;
	logic signed [34:0] s_q, c_q;
	logic [2:0]  n_q;
	logic        div_go_q;
	logic [33:0] div_dvd_q;
	logic [7:0]  div_dvs_q;
	logic        div_done;
	logic [31:0] div_quot;
	logic [F-1:0] sn_mag_q, cs_mag_q;
	logic        sn_neg_q, cs_neg_q;
	logic [1:0]  pidx_q, k_q;
	logic signed [PW-1:0] p_q [CORNERS];
	logic signed [SW-1:0] sumx_q, sumy_q;
	logic [CORNERS-1:0][31:0] cx_q, cy_q;
	logic        done_q, ins_q;

	logic [31:0] vxe, vye, mse;
	logic [F-1:0] ms_c, mc_c;
	logic [14:0] hx, hy;
	logic [31:0] op_a;
	logic [14:0] op_b;
	logic        op_neg;
	logic signed [PW-1:0] prod_s;
	logic signed [SW-1:0] sumx_c, sumy_c;
	logic [31:0] cornx_c, corny_c;

	mbsp_cdiv u_cdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_dvd_q),
		.divisor  (div_dvs_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk) begin
		prod_q <= mul_a_q * mul_b_q;
	end

	always_comb begin
		logic [34:0] s_cl, c_cl, sv, cv;
		vxe  = {{16{req_q.speed_x[15]}}, req_q.speed_x};
		vye  = {{16{req_q.speed_y[15]}}, req_q.speed_y};
		mse  = {16'd0, ms_q};
		s_cl = s_q[34] ? '0 : 35'(s_q);
		c_cl = c_q[34] ? '0 : 35'(c_q);
		sv   = (s_cl + HALF) >> SHIFT;
		cv   = (c_cl + HALF) >> SHIFT;
		ms_c = (sv > CAP) ? CAP[F-1:0] : sv[F-1:0];
		mc_c = (cv > CAP) ? CAP[F-1:0] : cv[F-1:0];
	end

	assign hx = req_q.size_x[15:1];
	assign hy = req_q.size_y[15:1];

	always_comb begin
		case (pidx_q)
			2'd0: begin op_a = 32'(cs_mag_q); op_b = hx; op_neg = cs_neg_q; end
			2'd1: begin op_a = 32'(sn_mag_q); op_b = hy; op_neg = sn_neg_q; end
			2'd2: begin op_a = 32'(sn_mag_q); op_b = hx; op_neg = sn_neg_q; end
			default: begin op_a = 32'(cs_mag_q); op_b = hy; op_neg = cs_neg_q; end
		endcase
	end

	assign prod_s = op_neg ? -$signed(PW'(prod_q)) : $signed(PW'(prod_q));

	always_comb begin
		logic sgx_neg, sgy_pos;
		logic signed [SW-1:0] e1, e2, e3, e4;
		sgx_neg = (k_q[0] == k_q[1]);
		sgy_pos = !k_q[1];
		e1 = SW'(p_q[0]);
		e2 = SW'(p_q[1]);
		e3 = SW'(p_q[2]);
		e4 = SW'(p_q[3]);
		sumx_c = (sgx_neg ? -e1 : e1) + (sgy_pos ? -e2 : e2);
		sumy_c = (sgx_neg ? -e3 : e3) + (sgy_pos ? e4 : -e4);
	end

	always_comb begin
		logic signed [SW-1:0] mx, my, scx, scy;
		mx  = sumx_q[SW-1] ? -sumx_q : sumx_q;
		my  = sumy_q[SW-1] ? -sumy_q : sumy_q;
		scx = SW'($unsigned(mx) >> F);
		scy = SW'($unsigned(my) >> F);
		scx = sumx_q[SW-1] ? -scx : scx;
		scy = sumy_q[SW-1] ? -scy : scy;
		cornx_c = 32'(req_q.obj_x) + scx[31:0];
		corny_c = 32'(req_q.obj_y) + scy[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= L_IDLE;
			req_q     <= '0;
			full_q    <= 1'b0;
			ms_q      <= '0;
			sqx_q     <= '0;
			sqy_q     <= '0;
			msq_q     <= '0;
			mul_a_q   <= '0;
			mul_b_q   <= '0;
			x2_q      <= '0;
			t_q       <= '0;
			u_q       <= '0;
			s_q       <= '0;
			c_q       <= '0;
			n_q       <= '0;
			div_go_q  <= 1'b0;
			div_dvd_q <= '0;
			div_dvs_q <= '0;
			sn_mag_q  <= '0;
			cs_mag_q  <= '0;
			sn_neg_q  <= 1'b0;
			cs_neg_q  <= 1'b0;
			pidx_q    <= '0;
			k_q       <= '0;
			for (int i = 0; i < CORNERS; i++) p_q[i] <= '0;
			sumx_q    <= '0;
			sumy_q    <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
			done_q    <= 1'b0;
			ins_q     <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			ins_q    <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start) begin
						req_q   <= req;
						full_q  <= full;
						ms_q    <= min_speed;
						state_q <= L_SQ;
					end
				end
				L_SQ: begin
					sqx_q   <= vxe * vxe;
					sqy_q   <= vye * vye;
					msq_q   <= mse * mse;
					state_q <= L_CHK;
				end
				L_CHK: begin
					if (({1'b0, sqx_q} + {1'b0, sqy_q}) < {1'b0, msq_q} || full_q) begin
						done_q  <= 1'b1;
						state_q <= L_IDLE;
					end else begin
						mul_a_q <= {18'd0, req_q.heading[13:0]};
						mul_b_q <= PI_Q30;
						state_q <= L_XW;
					end
				end
				L_XW: state_q <= L_XC;
				L_XC: begin
					t_q     <= {1'b0, prod_q[45:15]};
					s_q     <= $signed({4'd0, prod_q[45:15]});
					mul_a_q <= {1'b0, prod_q[45:15]};
					mul_b_q <= {1'b0, prod_q[45:15]};
					state_q <= L_X2W;
				end
				L_X2W: state_q <= L_X2C;
				L_X2C: begin
					x2_q    <= prod_q[61:30];
					u_q     <= 32'(ONE_Q30);
					c_q     <= ONE_Q30;
					n_q     <= 3'd1;
					mul_a_q <= t_q;
					mul_b_q <= prod_q[61:30];
					state_q <= L_TW;
				end
				L_TW: state_q <= L_TC;
				L_TC: begin
					div_go_q  <= 1'b1;
					div_dvd_q <= prod_q[63:30];
					div_dvs_q <= sin_div(n_q);
					state_q   <= L_TD;
				end
				L_TD: begin
					if (div_done) begin
						t_q     <= div_quot;
						s_q     <= n_q[0] ? s_q - $signed({3'd0, div_quot})
						                  : s_q + $signed({3'd0, div_quot});
						mul_a_q <= u_q;
						mul_b_q <= x2_q;
						state_q <= L_UW;
					end
				end
				L_UW: state_q <= L_UC;
				L_UC: begin
					div_go_q  <= 1'b1;
					div_dvd_q <= prod_q[63:30];
					div_dvs_q <= cos_div(n_q);
					state_q   <= L_UD;
				end
				L_UD: begin
					if (div_done) begin
						u_q <= div_quot;
						c_q <= n_q[0] ? c_q - $signed({3'd0, div_quot})
						              : c_q + $signed({3'd0, div_quot});
						if (n_q == 3'(TERMS)) begin
							state_q <= L_FRAC;
						end else begin
							n_q     <= n_q + 3'd1;
							mul_a_q <= t_q;
							mul_b_q <= x2_q;
							state_q <= L_TW;
						end
					end
				end
				L_FRAC: begin
					case (req_q.heading[15:14])
						2'd0: begin
							sn_mag_q <= ms_c; sn_neg_q <= 1'b0;
							cs_mag_q <= mc_c; cs_neg_q <= 1'b0;
						end
						2'd1: begin
							sn_mag_q <= mc_c; sn_neg_q <= 1'b0;
							cs_mag_q <= ms_c; cs_neg_q <= 1'b1;
						end
						2'd2: begin
							sn_mag_q <= ms_c; sn_neg_q <= 1'b1;
							cs_mag_q <= mc_c; cs_neg_q <= 1'b1;
						end
						default: begin
							sn_mag_q <= mc_c; sn_neg_q <= 1'b1;
							cs_mag_q <= ms_c; cs_neg_q <= 1'b0;
						end
					endcase
					pidx_q  <= '0;
					state_q <= L_PS;
				end
				L_PS: begin
					mul_a_q <= op_a;
					mul_b_q <= {17'd0, op_b};
					state_q <= L_PW;
				end
				L_PW: state_q <= L_PC;
				L_PC: begin
					p_q[pidx_q] <= prod_s;
					if (pidx_q == 2'd3) begin
						k_q     <= '0;
						state_q <= L_CS;
					end else begin
						pidx_q  <= pidx_q + 2'd1;
						state_q <= L_PS;
					end
				end
				L_CS: begin
					sumx_q  <= sumx_c;
					sumy_q  <= sumy_c;
					state_q <= L_CO;
				end
				L_CO: begin
					cx_q[k_q] <= cornx_c;
					cy_q[k_q] <= corny_c;
					if (k_q == 2'd3) begin
						state_q <= L_DONE;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= L_CS;
					end
				end
				L_DONE: begin
					done_q  <= 1'b1;
					ins_q   <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign busy = (state_q != L_IDLE);
	assign res  = '{done: done_q, box: '{valid: ins_q, cx: cx_q, cy: cy_q}};
endmodule

// ===== design/mbsp_boxtest.sv =====
// Crossing-number test of one scan point against the box at the chain tail.
// Depends on mbsp_pkg.
module mbsp_boxtest (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  logic               en,
	input  mbsp_pkg::box_t     box,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	output logic               hit
);
	import mbsp_pkg::*;

	logic                v_s1, v_s2, v_s3;
	logic signed [32:0]  dx_s1 [CORNERS];
	logic signed [32:0]  dy_s1 [CORNERS];
	logic [CORNERS-1:0]  eq_s2, sr_s2, sl_s2, dneg_s2, x1_s2, x2_s2;
	logic [63:0]         m1_s2 [CORNERS];
	logic [63:0]         m2_s2 [CORNERS];
	logic                in_s3;
	logic                acc_q;

	logic [CORNERS-1:0]  eq_c, sr_c, sl_c, dneg_c, x1_c, x2_c;
	logic [63:0]         m1_c [CORNERS];
	logic [63:0]         m2_c [CORNERS];
	logic                inbox_c;

	for (genvar g = 0; g < CORNERS; g++) begin : g_edge
		localparam int KP = (g + CORNERS - 1) % CORNERS;
		logic [33:0] dd;
		assign eq_c[g]  = (dx_s1[g] == '0) && (dy_s1[g] == '0);
		assign sr_c[g]  = (!dy_s1[g][32] && dy_s1[g] != '0) != (!dy_s1[KP][32] && dy_s1[KP] != '0);
		assign sl_c[g]  = dy_s1[g][32] != dy_s1[KP][32];
		assign dd       = {dy_s1[KP][32], dy_s1[KP]} - {dy_s1[g][32], dy_s1[g]};
		assign dneg_c[g] = dd[33];
		assign x1_c[g]  = dx_s1[g][32] != dy_s1[KP][32];
		assign x2_c[g]  = dy_s1[g][32] != dx_s1[KP][32];
		assign m1_c[g]  = mag33(dx_s1[g]) * mag33(dy_s1[KP]);
		assign m2_c[g]  = mag33(dy_s1[g]) * mag33(dx_s1[KP]);
	end

	always_comb begin
		logic n1, n2, gt, pos, ngt, lp, rp;
		lp = 1'b0;
		rp = 1'b0;
		for (int k = 0; k < CORNERS; k++) begin
			n1 = (m1_s2[k] != '0) && x1_s2[k];
			n2 = (m2_s2[k] != '0) && x2_s2[k];
			gt = m1_s2[k] > m2_s2[k];
			if (!n1 && n2) begin
				pos = 1'b1; ngt = 1'b0;
			end else if (n1 && !n2) begin
				pos = 1'b0; ngt = 1'b1;
			end else if (m1_s2[k] == m2_s2[k]) begin
				pos = 1'b0; ngt = 1'b0;
			end else if (!n1) begin
				pos = gt; ngt = !gt;
			end else begin
				pos = !gt; ngt = gt;
			end
			if (dneg_s2[k]) begin
				{pos, ngt} = {ngt, pos};
			end
			lp = lp ^ (sl_s2[k] && ngt);
			rp = rp ^ (sr_s2[k] && pos);
		end
		inbox_c = (|eq_s2) || (lp != rp) || rp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			acc_q <= 1'b0;
		end else begin
			v_s1 <= en && box.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (clr) begin
				acc_q <= 1'b0;
			end else if (v_s3 && in_s3) begin
				acc_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CORNERS; k++) begin
			dx_s1[k] <= $signed({box.cx[k][31], box.cx[k]}) - $signed({px[31], px});
			dy_s1[k] <= $signed({box.cy[k][31], box.cy[k]}) - $signed({py[31], py});
			m1_s2[k] <= m1_c[k];
			m2_s2[k] <= m2_c[k];
		end
		eq_s2   <= eq_c;
		sr_s2   <= sr_c;
		sl_s2   <= sl_c;
		dneg_s2 <= dneg_c;
		x1_s2   <= x1_c;
		x2_s2   <= x2_c;
		in_s3   <= inbox_c;
	end

	assign hit = acc_q;
endmodule

// ===== design/moving_box_scan_point_marker.sv =====
// Top level of the moving box scan point marker: command port, config port, box chain.
// Depends on mbsp_pkg, mbsp_cell, mbsp_objld, mbsp_boxtest and the assertion macros.
//
// Usage:
//   Commands: drive req_type and the payload with start high; a command is taken
//   at a clock edge where start is high and busy is low.
//   Clear (code 0) empties the box table in the cycle it is taken; busy stays low.
//   Add (code 1) checks the object speed against min_speed, then computes sine and
//   cosine by an eight-term series on one shared 32x32 multiplier and a constant
//   divider that yields four quotient bits per cycle, and rotates the four corners.
//   Busy stays high until the rotated box is stored, most of that time set by the
//   fourteen series divisions; a slow object or a full table ends it at the speed check.
//   Classify (code 2) rotates the box chain once past one test unit, one box per
//   cycle, then drains its three-stage pipeline before done.
//   Results: done is high for one cycle with flags_out and hit; there is no
//   backpressure, a result must be taken in that cycle. Code 3 is ignored.
//   Config: cfg_ready is always high; index 0 is min_speed, index 1 is mark_mask.
//   Reset: empty table, min_speed 300, mark_mask 1.
`include "moving_box_scan_point_marker_assert.svh"
module moving_box_scan_point_marker #(
	parameter int MAX_BOXES      = mbsp_pkg::MAX_BOXES_DEF,
	parameter int TRIG_FRAC_BITS = mbsp_pkg::TRIG_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic signed [31:0]          obj_x,
	input  logic signed [31:0]          obj_y,
	input  logic [15:0]                 heading,
	input  logic [15:0]                 size_x,
	input  logic [15:0]                 size_y,
	input  logic signed [15:0]          speed_x,
	input  logic signed [15:0]          speed_y,
	input  logic signed [31:0]          point_x,
	input  logic signed [31:0]          point_y,
	input  logic [15:0]                 point_flags,
	output logic                        done,
	output logic [15:0]                 flags_out,
	output logic                        hit,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mbsp_pkg::CFG_IW-1:0] cfg_index,
	input  logic [15:0]                 cfg_data
);
	import mbsp_pkg::*;

	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam int RW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

	typedef enum logic [1:0] {T_IDLE, T_LOAD, T_ROT, T_DRAIN} top_state_t;

	top_state_t          state_q;
	logic [CW-1:0]       cnt_q;
	logic [RW-1:0]       rot_q;
	logic [1:0]          drn_q;
	logic [15:0]         min_speed_q, mark_mask_q;
	logic signed [31:0]  px_q, py_q;
	logic [15:0]         pf_q;
	logic                done_q, hit_q;
	logic [15:0]         flags_q;

	logic                acc_en;
	logic                ld_start, ld_busy, acc_hit;
	ld_req_t             ld_req;
	ld_res_t             ld_res;
	chain_ctl_t          ctl;
	box_t                head;
	box_t                cell_out [MAX_BOXES];

	assign acc_en   = start && !busy;
	assign ld_start = acc_en && (req_type == REQ_ADD);
	assign ld_req   = '{obj_x: obj_x, obj_y: obj_y, heading: heading, size_x: size_x,
	                    size_y: size_y, speed_x: speed_x, speed_y: speed_y};

	assign ctl.shift = (state_q == T_ROT) || (ld_res.done && ld_res.box.valid);
	assign ctl.clear = acc_en && (req_type == REQ_CLEAR);
	assign head      = (state_q == T_ROT) ? cell_out[MAX_BOXES-1] : ld_res.box;

	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
		mbsp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.din    ((i == 0) ? head : cell_out[(i == 0) ? 0 : i - 1]),
			.dout   (cell_out[i])
		);
	end

	mbsp_objld #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_objld (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ld_start),
		.req       (ld_req),
		.full      (cnt_q == CW'(MAX_BOXES)),
		.min_speed (min_speed_q),
		.busy      (ld_busy),
		.res       (ld_res)
	);

	mbsp_boxtest u_boxtest (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (acc_en && (req_type == REQ_CLASSIFY)),
		.en     (state_q == T_ROT),
		.box    (cell_out[MAX_BOXES-1]),
		.px     (px_q),
		.py     (py_q),
		.hit    (acc_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q <= MIN_SPEED_RST;
			mark_mask_q <= MARK_MASK_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN_SPEED: min_speed_q <= cfg_data;
				CFG_MARK_MASK: mark_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			cnt_q   <= '0;
			rot_q   <= '0;
			drn_q   <= '0;
			px_q    <= '0;
			py_q    <= '0;
			pf_q    <= '0;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
			flags_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (acc_en) begin
						case (req_type)
							REQ_CLEAR: cnt_q <= '0;
							REQ_ADD:   state_q <= T_LOAD;
							REQ_CLASSIFY: begin
								px_q    <= point_x;
								py_q    <= point_y;
								pf_q    <= point_flags;
								rot_q   <= '0;
								state_q <= T_ROT;
							end
							default: ;
						endcase
					end
				end
				T_LOAD: begin
					if (ld_res.done) begin
						if (ld_res.box.valid) begin
							cnt_q <= cnt_q + CW'(1);
						end
						state_q <= T_IDLE;
					end
				end
				T_ROT: begin
					if (rot_q == RW'(MAX_BOXES - 1)) begin
						drn_q   <= '0;
						state_q <= T_DRAIN;
					end else begin
						rot_q <= rot_q + RW'(1);
					end
				end
				T_DRAIN: begin
					if (drn_q == 2'd3) begin
						done_q  <= 1'b1;
						hit_q   <= acc_hit;
						flags_q <= acc_hit ? (pf_q | mark_mask_q) : pf_q;
						state_q <= T_IDLE;
					end else begin
						drn_q <= drn_q + 2'd1;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != T_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign hit       = hit_q;
	assign flags_out = flags_q;

	`MBSP_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_q <= CW'(MAX_BOXES), "box count above capacity")
	`MBSP_ASSERT_IMP(a_ld_owned, ld_busy, state_q == T_LOAD, "loader runs outside load")
	`MBSP_ASSERT_NXT(a_cls_busy, acc_en && req_type == REQ_CLASSIFY, busy, "classify not busy")
	`MBSP_ASSERT_IMP(a_done_src, done, $past(state_q == T_DRAIN), "result without drain")
endmodule
